@@ hw/rtl/clni_pkg.sv @@
// shared types, constants and the control store of the 4-bit lcd interface
// no dependencies
package clni_pkg;

  typedef enum logic [1:0] {
    ModeInit   = 2'd0,
    ModeCmd    = 2'd1,
    ModeChar   = 2'd2,
    ModeCursor = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    EnKeep = 2'd0,
    EnLow  = 2'd1,
    EnHigh = 2'd2
  } en_op_e;

  typedef enum logic [2:0] {
    NibKeep  = 3'd0,
    NibHigh  = 3'd1,
    NibLow   = 3'd2,
    NibThree = 3'd3,
    NibTwo   = 3'd4
  } nib_op_e;

  typedef enum logic [1:0] {
    HoldOne     = 2'd0,
    HoldTwo     = 2'd1,
    HoldPowerUp = 2'd2,
    HoldTail    = 2'd3
  } hold_sel_e;

  typedef struct packed {
    en_op_e    en;
    nib_op_e   nib;
    logic      rs_clr;
    hold_sel_e hold;
    logic      seq_end;
  } ctrl_word_t;

  localparam int unsigned PcW         = 4;
  localparam int unsigned IdxW        = 3;
  localparam logic [PcW-1:0] PcInit   = 4'd0;
  localparam logic [PcW-1:0] PcByte   = 4'd7;
  localparam logic [IdxW-1:0] IdxLast = 3'd5;
  localparam logic [5:0] MaxCol       = 6'd40;
  localparam logic [3:0] PowerUpMs    = 4'd15;
  localparam logic [7:0] CmdClear     = 8'h01;
  localparam logic [7:0] CmdHome      = 8'h02;

  function automatic logic [7:0] init_byte(logic [IdxW-1:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h28;
      3'd1:    b = 8'h02;
      3'd2:    b = 8'h08;
      3'd3:    b = 8'h06;
      3'd4:    b = 8'h0C;
      default: b = 8'h01;
    endcase
    return b;
  endfunction

  function automatic ctrl_word_t ctrl_rom(logic [PcW-1:0] pc);
    ctrl_word_t w;
    case (pc)
      4'd0:    w = '{EnKeep, NibKeep,  1'b0, HoldPowerUp, 1'b0};
      4'd1:    w = '{EnHigh, NibThree, 1'b1, HoldOne,     1'b0};
      4'd2:    w = '{EnLow,  NibKeep,  1'b0, HoldTwo,     1'b0};
      4'd3:    w = '{EnHigh, NibThree, 1'b0, HoldOne,     1'b0};
      4'd4:    w = '{EnLow,  NibKeep,  1'b0, HoldTwo,     1'b0};
      4'd5:    w = '{EnHigh, NibTwo,   1'b0, HoldOne,     1'b0};
      4'd6:    w = '{EnLow,  NibKeep,  1'b0, HoldTwo,     1'b0};
      4'd7:    w = '{EnHigh, NibKeep,  1'b0, HoldOne,     1'b0};
      4'd8:    w = '{EnHigh, NibHigh,  1'b0, HoldOne,     1'b0};
      4'd9:    w = '{EnLow,  NibKeep,  1'b0, HoldOne,     1'b0};
      4'd10:   w = '{EnHigh, NibLow,   1'b0, HoldOne,     1'b0};
      4'd11:   w = '{EnLow,  NibKeep,  1'b0, HoldTail,    1'b1};
      default: w = '{EnKeep, NibKeep,  1'b0, HoldOne,     1'b1};
    endcase
    return w;
  endfunction

endpackage

@@ hw/rtl/char_lcd_nibble_interface_core.sv @@
// top level of the 4-bit character lcd interface: microcoded pin-state sequencer
// depends on clni_pkg for the control store, op codes and init byte table
//
// usage:
// - input channel (in_valid_i / in_stall_o) carries one request item: mode, value,
//   column, row. it is taken while in_valid_i is high and in_stall_o is low.
// - output channel (out_valid_o / out_stall_i) carries pin-state items: rs, enable,
//   data nibble, hold time in ms, and last on the final state of the request.
// - init emits 37 pin states, command, character and set cursor emit 5 each.
// - one control word of the step rom runs per cycle, so one pin state is produced
//   per cycle unless the receiver stalls; a taken request first sets the busy flag,
//   then its first state is registered in the output register. a request occupies
//   the block until its final state is stepped; no new request is taken before that.
// - in_stall_o is high while a request is being sequenced.
// - when the receiver stalls, the output register holds its item and the step
//   counter waits; the final item may still wait while the next request is taken.
// - reset clears the held pin levels to zero and leaves the block idle.
module char_lcd_nibble_interface_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          mode_i,
  input  logic [7:0]          value_i,
  input  logic [5:0]          column_i,
  input  logic [1:0]          row_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                rs_pin_o,
  output logic                enable_pin_o,
  output logic [3:0]          bus_nibble_o,
  output logic [3:0]          hold_ms_o,
  output logic                last_o
);
  import clni_pkg::*;

  logic                busy_q, busy_d;
  logic [PcW-1:0]      pc_q, pc_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic                is_init_q, is_init_d;
  logic [7:0]          byte_q, byte_d;
  logic [2:0]          tail_q, tail_d;
  logic [3:0]          held_nib_q, held_nib_d;
  logic                held_rs_q, held_rs_d;
  logic                held_en_q, held_en_d;
  logic                out_valid_q, out_valid_d;
  logic                out_rs_q, out_en_q, out_last_q;
  logic [3:0]          out_nib_q, out_hold_q;

  logic                in_acc;
  logic                step;
  logic                loop_back;
  logic                fin;
  ctrl_word_t          cw;
  logic [7:0]          cur_byte;
  logic [3:0]          hold_val;
  logic [5:0]          col_clamped;
  logic [5:0]          addr;

  assign in_stall_o = busy_q;
  assign in_acc     = in_valid_i && !busy_q;
  assign step       = busy_q && (!out_valid_q || !out_stall_i);
  assign cw         = ctrl_rom(pc_q);
  assign cur_byte   = is_init_q ? init_byte(idx_q) : byte_q;
  assign loop_back  = cw.seq_end && is_init_q && (idx_q != IdxLast);
  assign fin        = cw.seq_end && !loop_back;

  always_comb begin
    col_clamped = column_i;
    if (column_i == 6'd0) begin
      col_clamped = 6'd1;
    end else if (column_i > MaxCol) begin
      col_clamped = MaxCol;
    end
    addr = col_clamped - 6'd1;
  end

  always_comb begin
    case (cw.hold)
      HoldOne:     hold_val = 4'd1;
      HoldTwo:     hold_val = 4'd2;
      HoldPowerUp: hold_val = PowerUpMs;
      HoldTail: begin
        if (is_init_q) begin
          hold_val = (idx_q == IdxLast) ? 4'd4 : 4'd2;
        end else begin
          hold_val = {1'b0, tail_q};
        end
      end
      default:     hold_val = 4'd1;
    endcase
  end

  always_comb begin
    busy_d      = busy_q;
    pc_d        = pc_q;
    idx_d       = idx_q;
    is_init_d   = is_init_q;
    byte_d      = byte_q;
    tail_d      = tail_q;
    held_nib_d  = held_nib_q;
    held_rs_d   = held_rs_q;
    held_en_d   = held_en_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (in_acc) begin
      busy_d    = 1'b1;
      idx_d     = '0;
      is_init_d = (mode_i == ModeInit);
      pc_d      = (mode_i == ModeInit) ? PcInit : PcByte;
      byte_d    = value_i;
      tail_d    = 3'd1;
      case (mode_i)
        ModeCmd: begin
          held_rs_d = 1'b0;
          if (value_i == CmdClear || value_i == CmdHome) begin
            tail_d = 3'd3;
          end
        end
        ModeChar: begin
          held_rs_d = 1'b1;
        end
        ModeCursor: begin
          held_rs_d = 1'b0;
          byte_d    = {1'b1, (row_i != 2'd1), addr};
          tail_d    = 3'd2;
        end
        default: begin
        end
      endcase
    end

    if (step) begin
      case (cw.en)
        EnLow:   held_en_d = 1'b0;
        EnHigh:  held_en_d = 1'b1;
        default: held_en_d = held_en_q;
      endcase
      case (cw.nib)
        NibHigh:  held_nib_d = cur_byte[7:4];
        NibLow:   held_nib_d = cur_byte[3:0];
        NibThree: held_nib_d = 4'h3;
        NibTwo:   held_nib_d = 4'h2;
        default:  held_nib_d = held_nib_q;
      endcase
      if (cw.rs_clr) begin
        held_rs_d = 1'b0;
      end
      out_valid_d = 1'b1;
      if (loop_back) begin
        pc_d  = PcByte;
        idx_d = idx_q + 3'd1;
      end else if (fin) begin
        pc_d   = PcInit;
        busy_d = 1'b0;
      end else begin
        pc_d = pc_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= PcInit;
      idx_q       <= '0;
      is_init_q   <= 1'b0;
      held_nib_q  <= '0;
      held_rs_q   <= 1'b0;
      held_en_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      idx_q       <= idx_d;
      is_init_q   <= is_init_d;
      held_nib_q  <= held_nib_d;
      held_rs_q   <= held_rs_d;
      held_en_q   <= held_en_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    tail_q <= tail_d;
    if (step) begin
      out_rs_q   <= held_rs_d;
      out_en_q   <= held_en_d;
      out_nib_q  <= held_nib_d;
      out_hold_q <= hold_val;
      out_last_q <= fin;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign rs_pin_o     = out_rs_q;
  assign enable_pin_o = out_en_q;
  assign bus_nibble_o = out_nib_q;
  assign hold_ms_o    = out_hold_q;
  assign last_o       = out_last_q;

  a_fin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && fin |=> !busy_q && pc_q == PcInit)
    else $error("sequencer did not return to idle after final step");

  a_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> busy_q)
    else $error("accepted request did not start the sequencer");

  a_idle_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> pc_q == PcInit)
    else $error("step counter not parked while idle");

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> pc_q <= 4'd11 && idx_q <= IdxLast)
    else $error("step counter or byte index out of range");

  a_hold_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_hold_q != 4'd0)
    else $error("pin state issued with zero hold time");

endmodule
